// File: rtl/nat_port_mapping_table_top_macros.svh
// assertion macros used by the checker file
`ifndef NAT_PORT_MAPPING_TABLE_TOP_MACROS_SVH
`define NAT_PORT_MAPPING_TABLE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define NPTT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nptt assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define NPTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nptt assertion failed");

`endif

// File: rtl/nptt_pkg.sv
// types and constants of the nat port mapping table
package nptt_pkg;

    localparam int POOL_SIZE = 8192;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

    localparam logic [2:0] ACT_OUTBOUND = 3'd0;
    localparam logic [2:0] ACT_INBOUND  = 3'd1;
    localparam logic [2:0] ACT_TOUCH    = 3'd2;
    localparam logic [2:0] ACT_FLAGS    = 3'd3;
    localparam logic [2:0] ACT_SWEEP    = 3'd4;
    localparam logic [2:0] ACT_CLEAR    = 3'd5;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_NEW  = 2'd1;
    localparam logic [1:0] ST_NF   = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [2:0] CFG_BASE_PORT   = 3'd0;
    localparam logic [2:0] CFG_TCP_OPEN    = 3'd1;
    localparam logic [2:0] CFG_TCP_CLOSING = 3'd2;
    localparam logic [2:0] CFG_UDP         = 3'd3;
    localparam logic [2:0] CFG_OTHER       = 3'd4;

    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] FIN_RST_MASK = 8'h05;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [15:0] nat_port;
        logic [7:0]  tcp_flags;
        logic [47:0] now_ms;
    } nptt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] mapped_port;
        logic [31:0] orig_src_ip;
        logic [15:0] orig_src_port;
        logic [13:0] evicted_count;
    } nptt_out_t;

    typedef struct packed {
        logic        valid;
        logic        closing;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [47:0] last_seen;
    } nptt_entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        nptt_entry_t      wr_data;
    } nptt_ram_req_t;

endpackage

// File: rtl/nptt_store.sv
// slot store: one write port, one registered read port
module nptt_store (
    input  logic                   clk,
    input  nptt_pkg::nptt_ram_req_t req,
    output nptt_pkg::nptt_entry_t   rd_data
);
    import nptt_pkg::*;

    nptt_entry_t mem [POOL_SIZE];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// File: rtl/nptt_ctrl.sv
// sequencer: decode, clearing pass, slot scan, read-modify-write and result register
module nptt_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  nptt_pkg::nptt_in_t      in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output nptt_pkg::nptt_out_t     out_data,
    input  logic                    cfg_valid,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    output nptt_pkg::nptt_ram_req_t ram_req,
    input  nptt_pkg::nptt_entry_t   ram_rd
);
    import nptt_pkg::*;

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_SCAN, S_RD, S_CHK, S_DONE} state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             d_vld_reg, d_vld_next;
    logic [IDX_W-1:0] d_idx_reg, d_idx_next;
    nptt_in_t         req_reg, req_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic             ge_found_reg, ge_found_next;
    logic [IDX_W-1:0] ge_idx_reg, ge_idx_next;
    logic             any_found_reg, any_found_next;
    logic [IDX_W-1:0] any_idx_reg, any_idx_next;
    logic [13:0]      evict_reg, evict_next;
    logic             clr_reply_reg, clr_reply_next;
    nptt_out_t        res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    nptt_out_t        out_data_reg, out_data_next;

    logic [15:0] base_reg;
    logic [31:0] tcp_open_reg, tcp_closing_reg, udp_reg, other_reg;

    logic [16:0]      port_diff;
    logic             in_pool;
    logic             issue;
    logic             last;
    logic             key_match;
    logic [31:0]      limit;
    logic [48:0]      idle_diff;
    logic             evict;
    logic [IDX_W-1:0] pick;
    nptt_entry_t      wr_entry;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        port_diff = {1'b0, in_data.nat_port} - {1'b0, base_reg};
        in_pool   = port_diff < 17'(POOL_SIZE);
        issue     = cnt_reg < CNT_W'(POOL_SIZE);
        last      = d_vld_reg && (d_idx_reg == LAST_IDX);
        key_match = ram_rd.valid && ram_rd.proto == req_reg.proto
                    && ram_rd.src_ip == req_reg.src_ip && ram_rd.src_port == req_reg.src_port
                    && ram_rd.peer_ip == req_reg.peer_ip
                    && ram_rd.peer_port == req_reg.peer_port;
        if (ram_rd.proto == PROTO_TCP)
        begin
            limit = ram_rd.closing ? tcp_closing_reg : tcp_open_reg;
        end
        else if (ram_rd.proto == PROTO_UDP)
        begin
            limit = udp_reg;
        end
        else
        begin
            limit = other_reg;
        end
        // a slot seen later than now is never idle enough
        idle_diff = {1'b0, req_reg.now_ms} - {1'b0, ram_rd.last_seen};
        evict     = ram_rd.valid && !idle_diff[48] && (idle_diff[47:0] >= {16'b0, limit});

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        d_vld_next     = 1'b0;
        d_idx_next     = d_idx_reg;
        req_next       = req_reg;
        slot_next      = slot_reg;
        probe_next     = probe_reg;
        ge_found_next  = ge_found_reg;
        ge_idx_next    = ge_idx_reg;
        any_found_next = any_found_reg;
        any_idx_next   = any_idx_reg;
        evict_next     = evict_reg;
        clr_reply_next = clr_reply_reg;
        res_next       = res_reg;
        pick           = '0;
        wr_entry       = ram_rd;
        ram_req        = '0;

        unique case (state_reg)
            S_CLR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = cnt_reg[IDX_W-1:0];
                ram_req.wr_data = '0;
                cnt_next        = cnt_reg + 1'b1;
                probe_next      = '0;
                if (cnt_reg[IDX_W-1:0] == LAST_IDX)
                begin
                    state_next = clr_reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next       = in_data;
                    slot_next      = port_diff[IDX_W-1:0];
                    cnt_next       = '0;
                    ge_found_next  = 1'b0;
                    any_found_next = 1'b0;
                    evict_next     = '0;
                    clr_reply_next = 1'b1;
                    res_next       = '0;
                    res_next.status = ST_NF;
                    if (in_data.action == ACT_OUTBOUND || in_data.action == ACT_SWEEP)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (in_data.action == ACT_INBOUND || in_data.action == ACT_TOUCH
                             || in_data.action == ACT_FLAGS)
                    begin
                        state_next = in_pool ? S_RD : S_DONE;
                    end
                    else if (in_data.action == ACT_CLEAR)
                    begin
                        res_next.status = ST_HIT;
                        state_next      = S_CLR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                ram_req.rd_en   = issue;
                ram_req.rd_addr = cnt_reg[IDX_W-1:0];
                if (issue)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    d_vld_next = 1'b1;
                    d_idx_next = cnt_reg[IDX_W-1:0];
                end
                if (d_vld_reg && req_reg.action == ACT_SWEEP)
                begin
                    if (evict)
                    begin
                        wr_entry.valid   = 1'b0;
                        wr_entry.closing = 1'b0;
                        ram_req.wr_en    = 1'b1;
                        ram_req.wr_addr  = d_idx_reg;
                        ram_req.wr_data  = wr_entry;
                        evict_next       = evict_reg + 1'b1;
                    end
                    if (last)
                    begin
                        res_next.status        = ST_HIT;
                        res_next.evicted_count = evict_next;
                        state_next             = S_DONE;
                    end
                end
                else if (d_vld_reg)
                begin
                    if (key_match)
                    begin
                        wr_entry.last_seen   = req_reg.now_ms;
                        ram_req.wr_en        = 1'b1;
                        ram_req.wr_addr      = d_idx_reg;
                        ram_req.wr_data      = wr_entry;
                        res_next.status      = ST_HIT;
                        res_next.mapped_port = base_reg + 16'(d_idx_reg);
                        state_next           = S_DONE;
                    end
                    else
                    begin
                        if (!ram_rd.valid && !ge_found_reg && d_idx_reg >= probe_reg)
                        begin
                            ge_found_next = 1'b1;
                            ge_idx_next   = d_idx_reg;
                        end
                        if (!ram_rd.valid && !any_found_reg)
                        begin
                            any_found_next = 1'b1;
                            any_idx_next   = d_idx_reg;
                        end
                        if (last)
                        begin
                            state_next = S_DONE;
                            pick       = ge_found_next ? ge_idx_next : any_idx_next;
                            if (any_found_next)
                            begin
                                wr_entry.valid       = 1'b1;
                                wr_entry.closing     = 1'b0;
                                wr_entry.proto       = req_reg.proto;
                                wr_entry.src_ip      = req_reg.src_ip;
                                wr_entry.src_port    = req_reg.src_port;
                                wr_entry.peer_ip     = req_reg.peer_ip;
                                wr_entry.peer_port   = req_reg.peer_port;
                                wr_entry.last_seen   = req_reg.now_ms;
                                ram_req.wr_en        = 1'b1;
                                ram_req.wr_addr      = pick;
                                ram_req.wr_data      = wr_entry;
                                probe_next           = (pick == LAST_IDX) ? '0 : pick + 1'b1;
                                res_next.status      = ST_NEW;
                                res_next.mapped_port = base_reg + 16'(pick);
                            end
                            else
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                    end
                end
            end
            S_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = slot_reg;
                state_next      = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_DONE;
                if (ram_rd.valid)
                begin
                    if (req_reg.action == ACT_INBOUND)
                    begin
                        if (ram_rd.proto == req_reg.proto && ram_rd.peer_ip == req_reg.peer_ip
                            && ram_rd.peer_port == req_reg.peer_port)
                        begin
                            res_next.status        = ST_HIT;
                            res_next.orig_src_ip   = ram_rd.src_ip;
                            res_next.orig_src_port = ram_rd.src_port;
                        end
                    end
                    else
                    begin
                        if (req_reg.action == ACT_FLAGS
                            && (req_reg.tcp_flags & FIN_RST_MASK) != 8'h00)
                        begin
                            wr_entry.closing = 1'b1;
                        end
                        wr_entry.last_seen = req_reg.now_ms;
                        ram_req.wr_en      = 1'b1;
                        ram_req.wr_addr    = slot_reg;
                        ram_req.wr_data    = wr_entry;
                        res_next.status    = ST_HIT;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            cnt_reg         <= '0;
            d_vld_reg       <= 1'b0;
            probe_reg       <= '0;
            clr_reply_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            base_reg        <= 16'd49152;
            tcp_open_reg    <= 32'd7440000;
            tcp_closing_reg <= 32'd240000;
            udp_reg         <= 32'd120000;
            other_reg       <= 32'd60000;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            d_vld_reg     <= d_vld_next;
            probe_reg     <= probe_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_BASE_PORT:   base_reg        <= cfg_data[15:0];
                    CFG_TCP_OPEN:    tcp_open_reg    <= cfg_data;
                    CFG_TCP_CLOSING: tcp_closing_reg <= cfg_data;
                    CFG_UDP:         udp_reg         <= cfg_data;
                    CFG_OTHER:       other_reg       <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        d_idx_reg     <= d_idx_next;
        req_reg       <= req_next;
        slot_reg      <= slot_next;
        ge_found_reg  <= ge_found_next;
        ge_idx_reg    <= ge_idx_next;
        any_found_reg <= any_found_next;
        any_idx_reg   <= any_idx_next;
        evict_reg     <= evict_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

endmodule

// File: rtl/nat_port_mapping_table_top.sv
// top level of the nat port mapping table
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/stall   | nptt_in_t
//  out     | output    | out_valid/stall  | nptt_out_t
//  cfg     | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// outbound and sweep walk every slot through the store read port (an outbound hit stops at
// its slot); inbound, touch and flag record look up only the slot of their port.
// clear and reset run a clearing pass over all POOL_SIZE slots (8192) with in_stall high.
// the next transaction is taken while a result waits in the output register.
// cfg writes are always taken.
module nat_port_mapping_table_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nptt_pkg::nptt_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output nptt_pkg::nptt_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import nptt_pkg::*;

    nptt_ram_req_t ram_req;
    nptt_entry_t   ram_rd;

    assign cfg_ready = 1'b1;

    nptt_store u_store (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

    nptt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ram_req   (ram_req),
        .ram_rd    (ram_rd)
    );

endmodule

// File: rtl/nptt_checker.sv
// port-level checker for the nat port mapping table, bound to the top level
`include "nat_port_mapping_table_top_macros.svh"

module nptt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input nptt_pkg::nptt_in_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input nptt_pkg::nptt_out_t out_data,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [2:0]          cfg_index,
    input logic [31:0]         cfg_data
);
    import nptt_pkg::*;

    `NPTT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `NPTT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
    `NPTT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `NPTT_ASSERT_IMPL(a_port_only_on_map,
        out_valid && out_data.status != ST_HIT && out_data.status != ST_NEW,
        out_data.mapped_port == 16'd0)
    `NPTT_ASSERT_IMPL(a_sweep_fields,
        out_valid && out_data.evicted_count != 14'd0,
        out_data.mapped_port == 16'd0 && out_data.orig_src_ip == 32'd0)

endmodule

bind nat_port_mapping_table_top nptt_checker u_nptt_checker (.*);

// File: verif/nat_port_mapping_table_top_test.sv
// testbench for the nat port mapping table: directed and random transactions against a predictor
`timescale 1ns / 100ps

module nat_port_mapping_table_top_test;
    import nptt_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    nptt_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    nptt_out_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    nat_port_mapping_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted table contents and registers
    nptt_entry_t      slot_tab [POOL_SIZE];
    logic [IDX_W-1:0] probe_ptr;
    logic [15:0]      base_port;
    logic [31:0]      tmo_tcp_open;
    logic [31:0]      tmo_tcp_closing;
    logic [31:0]      tmo_udp;
    logic [31:0]      tmo_other;

    nptt_out_t pending_results[$];
    int        mismatch_count;
    int        burst_left;
    int        idle_cycles;
    int        stall_mode_left;
    logic      stall_mode;
    logic [47:0] clock_ms;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] timeout_of(nptt_entry_t e);
        if (e.proto == PROTO_TCP)
            return e.closing ? tmo_tcp_closing : tmo_tcp_open;
        if (e.proto == PROTO_UDP)
            return tmo_udp;
        return tmo_other;
    endfunction

    function automatic void flush_table();
        for (int i = 0; i < POOL_SIZE; i++)
            slot_tab[i] = '0;
        probe_ptr = '0;
    endfunction

    // slot for a translated port, or POOL_SIZE if out of pool or free
    function automatic int slot_of_port(logic [15:0] port);
        int idx;
        if (port < base_port)
            return POOL_SIZE;
        idx = int'(port) - int'(base_port);
        if (idx >= POOL_SIZE || !slot_tab[idx].valid)
            return POOL_SIZE;
        return idx;
    endfunction

    function automatic nptt_out_t translate(nptt_in_t it);
        nptt_out_t r;
        int        s;
        int        idx;
        int        freed;
        r = '0;
        r.status = ST_NF;
        s = POOL_SIZE;
        case (it.action)
            ACT_OUTBOUND:
            begin
                for (int i = 0; i < POOL_SIZE; i++)
                    if (slot_tab[i].valid && slot_tab[i].proto == it.proto
                        && slot_tab[i].src_ip == it.src_ip
                        && slot_tab[i].src_port == it.src_port
                        && slot_tab[i].peer_ip == it.peer_ip
                        && slot_tab[i].peer_port == it.peer_port)
                    begin
                        s = i;
                        break;
                    end
                if (s < POOL_SIZE)
                begin
                    slot_tab[s].last_seen = it.now_ms;
                    r.status = ST_HIT;
                    r.mapped_port = base_port + 16'(s);
                end
                else
                begin
                    for (int i = 0; i < POOL_SIZE; i++)
                    begin
                        idx = (int'(probe_ptr) + i) % POOL_SIZE;
                        if (!slot_tab[idx].valid)
                        begin
                            s = idx;
                            break;
                        end
                    end
                    if (s < POOL_SIZE)
                    begin
                        probe_ptr = IDX_W'((s + 1) % POOL_SIZE);
                        slot_tab[s].valid = 1'b1;
                        slot_tab[s].closing = 1'b0;
                        slot_tab[s].proto = it.proto;
                        slot_tab[s].src_ip = it.src_ip;
                        slot_tab[s].src_port = it.src_port;
                        slot_tab[s].peer_ip = it.peer_ip;
                        slot_tab[s].peer_port = it.peer_port;
                        slot_tab[s].last_seen = it.now_ms;
                        r.status = ST_NEW;
                        r.mapped_port = base_port + 16'(s);
                    end
                    else
                        r.status = ST_FULL;
                end
            end
            ACT_INBOUND:
            begin
                s = slot_of_port(it.nat_port);
                if (s < POOL_SIZE && slot_tab[s].proto == it.proto
                    && slot_tab[s].peer_ip == it.peer_ip
                    && slot_tab[s].peer_port == it.peer_port)
                begin
                    r.status = ST_HIT;
                    r.orig_src_ip = slot_tab[s].src_ip;
                    r.orig_src_port = slot_tab[s].src_port;
                end
            end
            ACT_TOUCH, ACT_FLAGS:
            begin
                s = slot_of_port(it.nat_port);
                if (s < POOL_SIZE)
                begin
                    if (it.action == ACT_FLAGS && (it.tcp_flags & FIN_RST_MASK) != 0)
                        slot_tab[s].closing = 1'b1;
                    slot_tab[s].last_seen = it.now_ms;
                    r.status = ST_HIT;
                end
            end
            ACT_SWEEP:
            begin
                freed = 0;
                // a slot seen later than now is never evicted
                for (int i = 0; i < POOL_SIZE; i++)
                    if (slot_tab[i].valid && it.now_ms >= slot_tab[i].last_seen
                        && (it.now_ms - slot_tab[i].last_seen) >= 48'(timeout_of(slot_tab[i])))
                    begin
                        slot_tab[i].valid = 1'b0;
                        slot_tab[i].closing = 1'b0;
                        freed++;
                    end
                r.status = ST_HIT;
                r.evicted_count = 14'(freed);
            end
            ACT_CLEAR:
            begin
                flush_table();
                r.status = ST_HIT;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic nptt_in_t make_item(logic [2:0] act, logic [7:0] proto,
                                           logic [31:0] sip, logic [15:0] sport,
                                           logic [31:0] pip, logic [15:0] pport,
                                           logic [15:0] nport, logic [7:0] flags,
                                           logic [47:0] now);
        nptt_in_t it;
        it.action = act;
        it.proto = proto;
        it.src_ip = sip;
        it.src_port = sport;
        it.peer_ip = pip;
        it.peer_port = pport;
        it.nat_port = nport;
        it.tcp_flags = flags;
        it.now_ms = now;
        return it;
    endfunction

    task automatic send_item(nptt_in_t it);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(translate(it));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic wait_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // only called with the table idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE_PORT:   base_port = value[15:0];
            CFG_TCP_OPEN:    tmo_tcp_open = value;
            CFG_TCP_CLOSING: tmo_tcp_closing = value;
            CFG_UDP:         tmo_udp = value;
            CFG_OTHER:       tmo_other = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic idle_then_write(logic [2:0] idx, logic [31:0] value);
        in_valid <= 1'b0;
        wait_results();
        write_reg(idx, value);
    endtask

    task automatic test_outbound_inbound();
        send_item(make_item(ACT_OUTBOUND, PROTO_TCP, 32'h0a000001, 16'd1234,
                            32'h08080808, 16'd443, 16'd0, 8'h00, 48'd1000));
        send_item(make_item(ACT_OUTBOUND, PROTO_TCP, 32'h0a000001, 16'd1234,
                            32'h08080808, 16'd443, 16'd0, 8'h00, 48'd2000));
        send_item(make_item(ACT_OUTBOUND, PROTO_UDP, 32'hffffffff, 16'hffff,
                            32'hffffffff, 16'hffff, 16'hffff, 8'hff, 48'hffffffffffff));
        send_item(make_item(ACT_OUTBOUND, 8'd1, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0,
                            8'h00, 48'd0));
        send_item(make_item(ACT_INBOUND, PROTO_TCP, 32'h0, 16'd0, 32'h08080808,
                            16'd443, base_port, 8'h00, 48'd2500));
        // stored key differs in peer port, then in protocol
        send_item(make_item(ACT_INBOUND, PROTO_TCP, 32'h0, 16'd0, 32'h08080808,
                            16'd444, base_port, 8'h00, 48'd2500));
        send_item(make_item(ACT_INBOUND, PROTO_UDP, 32'h0, 16'd0, 32'h08080808,
                            16'd443, base_port, 8'h00, 48'd2500));
    endtask

    task automatic test_port_bounds();
        send_item(make_item(ACT_INBOUND, PROTO_TCP, 32'h0, 16'd0, 32'h08080808,
                            16'd443, base_port - 16'd1, 8'h00, 48'd0));
        send_item(make_item(ACT_TOUCH, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0,
                            base_port + 16'(POOL_SIZE), 8'h00, 48'd3000));
        send_item(make_item(ACT_TOUCH, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0,
                            base_port + 16'd1, 8'h00, 48'd3000));
        // free slot inside the pool
        send_item(make_item(ACT_FLAGS, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0,
                            base_port + 16'd9, 8'h05, 48'd3000));
    endtask

    task automatic test_flags_sweep();
        send_item(make_item(ACT_FLAGS, PROTO_TCP, 32'h0, 16'd0, 32'h0, 16'd0,
                            base_port, 8'h01, 48'd4000));
        // flags latched on a non-tcp entry too
        send_item(make_item(ACT_FLAGS, PROTO_UDP, 32'h0, 16'd0, 32'h0, 16'd0,
                            base_port + 16'd1, 8'h04, 48'd4000));
        send_item(make_item(ACT_FLAGS, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0,
                            base_port + 16'd2, 8'hfa, 48'd4000));
        send_item(make_item(3'd6, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, base_port,
                            8'h00, 48'd0));
        send_item(make_item(3'd7, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, base_port,
                            8'h00, 48'd0));
        // clock behind every entry
        send_item(make_item(ACT_SWEEP, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, 16'd0,
                            8'h00, 48'd0));
        idle_then_write(CFG_TCP_OPEN, 32'd0);
        idle_then_write(CFG_TCP_CLOSING, 32'd0);
        idle_then_write(CFG_UDP, 32'd0);
        idle_then_write(CFG_OTHER, 32'd0);
        send_item(make_item(ACT_SWEEP, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, 16'd0,
                            8'h00, 48'd4000));
        send_item(make_item(ACT_SWEEP, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, 16'd0,
                            8'h00, 48'hffffffffffff));
    endtask

    task automatic test_clear_and_wrap();
        send_item(make_item(ACT_CLEAR, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, 16'd0,
                            8'h00, 48'd0));
        idle_then_write(CFG_BASE_PORT, 32'h0000ffff);
        send_item(make_item(ACT_OUTBOUND, PROTO_UDP, 32'h1, 16'd1, 32'h2, 16'd2,
                            16'd0, 8'h00, 48'd10));
        // port past 65535 wraps to zero
        send_item(make_item(ACT_OUTBOUND, PROTO_UDP, 32'h1, 16'd1, 32'h2, 16'd3,
                            16'd0, 8'h00, 48'd10));
        send_item(make_item(ACT_INBOUND, PROTO_UDP, 32'h0, 16'd0, 32'h2, 16'd3,
                            16'd0, 8'h00, 48'd10));
        idle_then_write(CFG_BASE_PORT, 32'd1);
        idle_then_write(CFG_TCP_OPEN, 32'hffffffff);
        idle_then_write(CFG_UDP, 32'hffffffff);
        send_item(make_item(ACT_SWEEP, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, 16'd0,
                            8'h00, 48'hffffffffffff));
        idle_then_write(CFG_BASE_PORT, 32'd57344);
    endtask

    task automatic test_random(int count);
        nptt_in_t   it;
        int         pick;
        int         s;
        logic [7:0] protos [4];
        protos = '{PROTO_TCP, PROTO_UDP, 8'd1, 8'd47};
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                idle_then_write(CFG_TCP_OPEN, $urandom_range(0, 3000));
                idle_then_write(CFG_TCP_CLOSING, $urandom_range(0, 1000));
                idle_then_write(CFG_UDP, $urandom_range(0, 2000));
                idle_then_write(CFG_OTHER, $urandom);
                idle_then_write(CFG_BASE_PORT, $urandom_range(1, 57344));
            end
            clock_ms = clock_ms + 48'($urandom_range(0, 1500));
            it = make_item(3'($urandom_range(0, 7)), protos[$urandom_range(0, 3)],
                           32'h0a000000 | $urandom_range(0, 3), 16'($urandom_range(1000, 1003)),
                           32'hc0a80001, 16'($urandom_range(80, 81)),
                           base_port + 16'($urandom_range(0, 12)), 8'($urandom), clock_ms);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                it.action = ACT_OUTBOUND;
            else if (pick < 65)
            begin
                // inbound that mostly matches a stored key
                it.action = ACT_INBOUND;
                s = slot_of_port(it.nat_port);
                if (s < POOL_SIZE && $urandom_range(0, 3) != 0)
                begin
                    it.proto = slot_tab[s].proto;
                    it.peer_ip = slot_tab[s].peer_ip;
                    it.peer_port = slot_tab[s].peer_port;
                end
            end
            else if (pick < 80)
                it.action = $urandom_range(0, 1) ? ACT_TOUCH : ACT_FLAGS;
            else if (pick < 86)
                it.action = ACT_SWEEP;
            else if (pick < 95)
            begin
                // noise over the whole range of every field, with clear turned into touch
                it = make_item(3'($urandom_range(0, 7)), 8'($urandom), $urandom, 16'($urandom),
                               $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
                               {16'($urandom), 32'($urandom)});
                if (it.action == ACT_CLEAR)
                    it.action = ACT_TOUCH;
            end
            else if (pick < 97)
                it.action = ACT_CLEAR;
            if (n == count / 4)
            begin
                in_valid <= 1'b0;
                wait_results();
            end
            send_item(it);
        end
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %p", out_data);
            end
            else
            begin
                nptt_out_t exp_r;
                exp_r = pending_results.pop_front();
                if (out_data.status !== exp_r.status
                    || out_data.mapped_port !== exp_r.mapped_port
                    || out_data.orig_src_ip !== exp_r.orig_src_ip
                    || out_data.orig_src_port !== exp_r.orig_src_port
                    || out_data.evicted_count !== exp_r.evicted_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: status %0d/%0d port %0d/%0d",
                                 exp_r.status, out_data.status,
                                 exp_r.mapped_port, out_data.mapped_port,
                                 " ip %h/%h sport %0d/%0d evicted %0d/%0d",
                                 exp_r.orig_src_ip, out_data.orig_src_ip,
                                 exp_r.orig_src_port, out_data.orig_src_port,
                                 exp_r.evicted_count, out_data.evicted_count);
                end
            end
        end
    end

    // receiver stall pattern: stretches of random stalls and stretches of none
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 1);
            stall_mode_left <= $urandom_range(20, 400);
        end
        else
            stall_mode_left <= stall_mode_left - 1;
        out_stall <= stall_mode && ($urandom_range(0, 2) != 0);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BASE_PORT;
        cfg_data = '0;
        stall_mode = 1'b0;
        stall_mode_left = 0;
        idle_cycles = 0;
        mismatch_count = 0;
        burst_left = 0;
        clock_ms = 48'd5000;
        base_port = 16'd49152;
        tmo_tcp_open = 32'd7440000;
        tmo_tcp_closing = 32'd240000;
        tmo_udp = 32'd120000;
        tmo_other = 32'd60000;
        flush_table();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_outbound_inbound();
        test_port_bounds();
        test_flags_sweep();
        test_clear_and_wrap();
        test_random(100);

        in_valid <= 1'b0;
        wait_results();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/nptt_pkg.sv
rtl/nptt_store.sv
rtl/nptt_ctrl.sv
rtl/nat_port_mapping_table_top.sv
rtl/nptt_checker.sv
verif/nat_port_mapping_table_top_test.sv
